@@ rtl/cfrb_pkg.sv @@
// Shared types, codes and reset values for the command frame ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package cfrb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 10;
  localparam int unsigned FILL_W        = 10;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_POLL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_START_CODE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 8'd3;

  localparam logic [7:0]        START_CODE_RST     = 8'd2;
  localparam logic [7:0]        END_CODE_RST       = 8'd3;
  localparam logic [7:0]        ESCAPE_CODE_RST    = 8'd27;
  localparam logic [FILL_W-1:0] OVERFLOW_LIMIT_RST = 10'd768;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        data_out;
    logic              command_ready;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        start_code;
    logic [7:0]        end_code;
    logic [7:0]        escape_code;
    logic [FILL_W-1:0] overflow_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/cfrb_ram.sv @@
// Byte storage of the ring: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cfrb_ram #(
  parameter int unsigned DEPTH = cfrb_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/cfrb_ctrl.sv @@
// Sequencer for push, pop and frame poll, with the pointers and the output register.
`timescale 1ns / 1ps
`default_nettype none

module cfrb_ctrl #(
  parameter int unsigned DEPTH = cfrb_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfrb_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cfrb_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cfrb_pkg::out_item_t      out_data_o,
  output logic                     mem_we_o,
  output logic [AW-1:0]            mem_waddr_o,
  output logic [7:0]               mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AW-1:0]            mem_raddr_o,
  input  wire logic [7:0]          mem_rdata_i
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_POP     = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_CHK_ESC = 6'b001000,
    ST_CHK_END = 6'b010000,
    ST_RESP    = 6'b100000
  } state_e;

  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  state_e              state_q, state_d;
  logic [AW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic                wrap_q, wrap_d;
  logic                rd_ok_q, rd_ok_d;
  logic                out_valid_q, out_valid_d;
  cfrb_pkg::out_item_t out_q, out_d;
  cfrb_pkg::status_e   res_status_q, res_status_d;
  logic [7:0]          res_data_q, res_data_d;
  logic                res_ready_q, res_ready_d;

  logic [AW-1:0] wptr_inc, rptr_inc, wptr_m1, wptr_m2, fill;
  logic [AW:0]   wptr_m1_x, wptr_m2_x, fill_x;
  logic [31:0]   fill_32;
  logic          full, empty;
  logic [7:0]    rd_byte;

  assign wptr_inc  = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
  assign rptr_inc  = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
  assign wptr_m1_x = (wptr_q >= AW'(1)) ? {1'b0, wptr_q} - (AW + 1)'(1)
                                        : {1'b0, wptr_q} + DEPTH_X - (AW + 1)'(1);
  assign wptr_m2_x = (wptr_q >= AW'(2)) ? {1'b0, wptr_q} - (AW + 1)'(2)
                                        : {1'b0, wptr_q} + DEPTH_X - (AW + 1)'(2);
  assign wptr_m1   = wptr_m1_x[AW-1:0];
  assign wptr_m2   = wptr_m2_x[AW-1:0];
  assign fill_x    = (wptr_q >= rptr_q) ? {1'b0, wptr_q} - {1'b0, rptr_q}
                                        : {1'b0, wptr_q} + DEPTH_X - {1'b0, rptr_q};
  assign fill      = fill_x[AW-1:0];
  assign fill_32   = 32'(fill);
  assign full      = (wptr_inc == rptr_q);
  assign empty     = (wptr_q == rptr_q);

  // Entries that were never written since reset read as zero.
  assign rd_byte = rd_ok_q ? mem_rdata_i : 8'd0;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    wptr_d       = wptr_q;
    rptr_d       = rptr_q;
    wrap_d       = wrap_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_ready_d  = res_ready_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = wptr_q;
    mem_wdata_o  = in_data_i.data_in;
    mem_re_o     = 1'b0;
    mem_raddr_o  = rptr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = cfrb_pkg::STS_OK;
          res_data_d   = 8'd0;
          res_ready_d  = 1'b0;
          state_d      = ST_RESP;
          unique case (in_data_i.cmd)
            cfrb_pkg::CMD_PUSH: begin
              if (full) begin
                res_status_d = cfrb_pkg::STS_FULL;
              end else begin
                mem_we_o = 1'b1;
                wptr_d   = wptr_inc;
                if (wptr_q == LAST) begin
                  wrap_d = 1'b1;
                end
              end
            end
            cfrb_pkg::CMD_POP: begin
              if (empty) begin
                res_status_d = cfrb_pkg::STS_EMPTY;
              end else begin
                mem_re_o = 1'b1;
                state_d  = ST_POP;
              end
            end
            cfrb_pkg::CMD_POLL: begin
              if (!empty) begin
                mem_re_o = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_POP: begin
        res_data_d = rd_byte;
        rptr_d     = rptr_inc;
        state_d    = ST_RESP;
      end
      ST_SCAN: begin
        if (rd_byte == cfg_i.start_code) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = wptr_m2;
          state_d     = ST_CHK_ESC;
        end else begin
          rptr_d = rptr_inc;
          if (rptr_inc == wptr_q) begin
            state_d = ST_RESP;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = rptr_inc;
          end
        end
      end
      ST_CHK_ESC: begin
        if (rd_byte == cfg_i.escape_code) begin
          state_d = ST_RESP;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = wptr_m1;
          state_d     = ST_CHK_END;
        end
      end
      ST_CHK_END: begin
        if (rd_byte == cfg_i.end_code) begin
          res_ready_d = 1'b1;
        end else if (fill_32 > 32'(cfg_i.overflow_limit)) begin
          rptr_d = wptr_q;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status        = res_status_q;
          out_d.data_out      = res_data_q;
          out_d.command_ready = res_ready_q;
          out_d.fill_level    = fill_32[cfrb_pkg::FILL_W-1:0];
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_ok_d = wrap_q || (mem_raddr_o < wptr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      wrap_q      <= wrap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_ready_q  <= res_ready_d;
    out_q        <= out_d;
    if (mem_re_o) begin
      rd_ok_q <= rd_ok_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/command_frame_ring_buffer_core.sv @@
// Top level of the command frame ring buffer: configuration registers, sequencer and storage.
`timescale 1ns / 1ps
`default_nettype none

// The input channel carries one operation per beat: push a byte, pop the oldest
// byte, or poll for a complete command frame. Every input beat yields exactly one
// output beat with a status, the popped byte, the poll flag and the fill level.
// A push, an unused command, an empty pop or a full push goes from acceptance
// through the response state to the output register; a successful pop first reads
// the byte in its own state. A poll examines the bytes at the head one at a time
// (dropped bytes and the start code). When a start code is found, it reads the
// older of the two newest slots and then, unless that slot holds the escape code,
// the newer one. Each step is bounded by the single read port of the byte memory,
// whose data arrive in the cycle after the address. One operation is in progress at a time; the next beat is
// accepted once the result has moved to the output register, even if the receiver
// has not taken it yet. If the receiver stalls, the finished result of the
// following operation waits in the sequencer and the input channel stays blocked.
// The configuration channel is always ready and should only be written while the
// block is idle. Reset empties the buffer and restores the default codes; storage
// slots never written since reset read as zero without any clearing pass.
module command_frame_ring_buffer_core #(
  parameter int unsigned DEPTH = cfrb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire cfrb_pkg::in_item_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output cfrb_pkg::out_item_t                      out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [cfrb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [cfrb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);

  cfrb_pkg::cfg_t cfg_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code     <= cfrb_pkg::START_CODE_RST;
      cfg_q.end_code       <= cfrb_pkg::END_CODE_RST;
      cfg_q.escape_code    <= cfrb_pkg::ESCAPE_CODE_RST;
      cfg_q.overflow_limit <= cfrb_pkg::OVERFLOW_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cfrb_pkg::REG_START_CODE:     cfg_q.start_code     <= cfg_data_i[7:0];
        cfrb_pkg::REG_END_CODE:       cfg_q.end_code       <= cfg_data_i[7:0];
        cfrb_pkg::REG_ESCAPE_CODE:    cfg_q.escape_code    <= cfg_data_i[7:0];
        cfrb_pkg::REG_OVERFLOW_LIMIT: cfg_q.overflow_limit <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  cfrb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cfrb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/cfrb_checker.sv @@
// Port-level checks of the command frame ring buffer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module cfrb_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire cfrb_pkg::out_item_t out_data_i
);

  // A stalled output beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output payload changed while stalled");

  // A failed pop leaves nothing in the buffer and returns no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == cfrb_pkg::STS_EMPTY) |->
      (out_data_i.data_out == 8'd0) && (out_data_i.fill_level == '0))
    else $error("empty status with data or nonzero fill level");

  // A complete frame is only reported on a successful poll of a nonempty buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.command_ready |->
      (out_data_i.status == cfrb_pkg::STS_OK) && (out_data_i.fill_level != '0) &&
      (out_data_i.data_out == 8'd0))
    else $error("command ready reported inconsistently");

endmodule

bind command_frame_ring_buffer_core cfrb_checker u_cfrb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
